// File: design/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

    typedef struct packed {
        logic [2:0]  seq_num;
        logic        check_ok;
        logic [63:0] payload_word;
    } t_in_word;

    typedef struct packed {
        logic signed [3:0] ack_num;
        logic              deliver;
        logic [63:0]       payload_out;
        logic              last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  seq_num;
        logic        beyond;
        logic [63:0] payload;
    } t_queue_word;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } t_back_state;

    localparam logic signed [3:0] ACK_NONE = -4'sd1;

endpackage

// File: design/srr_front.sv
`timescale 1ns / 1ps

module srr_front #(
    parameter int SEQ_SPACE = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srr_pkg::t_in_word   i_in_word,
    output logic                o_q_valid,
    input  logic                i_q_full,
    output srr_pkg::t_queue_word o_q_word
);
    import srr_pkg::*;

    logic        r_valid;
    t_queue_word r_item;
    logic        accept;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_valid  = r_valid;
    assign o_q_word   = r_item;

    // Corrupt words are dropped here; numbers past the sequence space are flagged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= i_in_word.check_ok;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.seq_num <= i_in_word.seq_num;
            r_item.beyond  <= (int'(i_in_word.seq_num) >= SEQ_SPACE);
            r_item.payload <= i_in_word.payload_word;
        end
    end

endmodule

// File: design/srr_fifo.sv
`timescale 1ns / 1ps

module srr_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  srr_pkg::t_queue_word i_word,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_pop,
    output srr_pkg::t_queue_word o_word
);
    import srr_pkg::*;

    t_queue_word r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/srr_back.sv
`timescale 1ns / 1ps

module srr_back #(
    parameter int WINDOW    = 4,
    parameter int SEQ_SPACE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  srr_pkg::t_queue_word i_q_word,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output srr_pkg::t_out_word   o_out_word
);
    import srr_pkg::*;

    localparam int SW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
    localparam int DW = ((SW > 5) ? SW : 5) + 2;
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int AW = (SW > 4) ? SW : 4;

    t_back_state       r_state, n_state;
    logic [SW-1:0]     r_base, n_base;
    logic [WINDOW-1:0] r_held, n_held;
    logic [63:0]       r_slot [WINDOW];
    logic signed [3:0] r_last_ack, n_last_ack;
    logic              r_out_valid;
    t_out_word         r_out;

    t_out_word         n_out;
    logic              emit;
    logic              out_free;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic              shift;
    logic [DW-1:0]     diff_raw;
    logic [DW-1:0]     diff;
    logic              in_window;
    logic [WINDOW-1:0] held_up;
    logic [SW-1:0]     base_inc;
    logic [AW-1:0]     base_wide;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign diff_raw  = DW'(i_q_word.seq_num) + DW'(SEQ_SPACE) - DW'(r_base);
    assign diff      = (diff_raw >= DW'(SEQ_SPACE)) ? diff_raw - DW'(SEQ_SPACE) : diff_raw;
    assign in_window = !i_q_word.beyond && (diff < DW'(WINDOW));
    assign wr_idx    = diff[IW-1:0];
    assign held_up   = r_held >> 1;
    assign base_inc  = (r_base == SW'(SEQ_SPACE - 1)) ? '0 : r_base + 1'b1;
    assign base_wide = AW'(r_base);

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_held     = r_held;
        n_last_ack = r_last_ack;
        n_out      = '0;
        emit       = 1'b0;
        o_q_pop    = 1'b0;
        wr_en      = 1'b0;
        shift      = 1'b0;
        case (r_state)
            BACK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (!in_window) begin
                        emit              = 1'b1;
                        n_out.ack_num     = $signed({1'b0, i_q_word.seq_num});
                        n_out.last_of_run = 1'b1;
                    end else begin
                        if (!r_held[wr_idx]) begin
                            wr_en          = 1'b1;
                            n_held[wr_idx] = 1'b1;
                        end
                        if (diff != '0) begin
                            emit              = 1'b1;
                            n_out.ack_num     = r_last_ack;
                            n_out.last_of_run = 1'b1;
                        end else begin
                            n_state = BACK_RUN;
                        end
                    end
                end
            end
            BACK_RUN: begin
                if (out_free) begin
                    emit              = 1'b1;
                    shift             = 1'b1;
                    n_out.ack_num     = $signed(base_wide[3:0]);
                    n_out.deliver     = 1'b1;
                    n_out.payload_out = r_slot[0];
                    n_out.last_of_run = !held_up[0];
                    n_last_ack        = $signed(base_wide[3:0]);
                    n_held            = held_up;
                    n_base            = base_inc;
                    if (!held_up[0]) begin
                        n_state = BACK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_IDLE;
            r_base      <= '0;
            r_held      <= '0;
            r_last_ack  <= ACK_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_held     <= n_held;
            r_last_ack <= n_last_ack;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[wr_idx] <= i_q_word.payload;
        end else if (shift) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                r_slot[k] <= r_slot[k + 1];
            end
        end
    end

endmodule

// File: design/selective_repeat_receiver_unit.sv
`timescale 1ns / 1ps
// An accepted word is held in the front register, then pushed into the queue when it is
// not full. Its first result is registered at the output, via the run state for a word
// at the window base, which releases a run of deliveries, one result per cycle while the
// output is not stalled; other checked words give one acknowledgement, corrupt ones none.
// Reset is synchronous and active low: it empties the queue, sets the window base
// to zero, clears all slot flags and sets the last acknowledgement to -1.

module selective_repeat_receiver_unit #(
    parameter int WINDOW    = 4,
    parameter int SEQ_SPACE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srr_pkg::t_out_word o_out_word
);
    import srr_pkg::*;

    logic        front_valid;
    t_queue_word front_word;
    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    t_queue_word q_word;

    assign q_push = front_valid && !q_full;

    srr_front #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_q_valid  (front_valid),
        .i_q_full   (q_full),
        .o_q_word   (front_word)
    );

    srr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_word  (q_word)
    );

    srr_back #(
        .WINDOW    (WINDOW),
        .SEQ_SPACE (SEQ_SPACE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_word    (q_word),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// File: dv/selective_repeat_receiver_unit_test.sv
`timescale 1ns / 1ps

module selective_repeat_receiver_unit_test;

    import srr_pkg::*;

    localparam int WINDOW      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    logic [2:0]  win_base;
    logic        slot_full [WINDOW];
    logic [63:0] slot_word [WINDOW];
    logic [3:0]  last_ack;
    t_out_word   ack_queue [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    selective_repeat_receiver_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_word make_ack(logic [3:0] ack, logic dlv, logic [63:0] pay,
                                           logic last);
        t_out_word r;
        r.ack_num     = ack;
        r.deliver     = dlv;
        r.payload_out = pay;
        r.last_of_run = last;
        return r;
    endfunction

    task automatic note_expected(t_out_word w);
        ack_queue.insert(ack_queue.size(), w);
    endtask

    task automatic clear_window();
        win_base = '0;
        last_ack = ACK_NONE;
        for (int k = 0; k < WINDOW; k++) begin
            slot_full[k] = 1'b0;
            slot_word[k] = '0;
        end
    endtask

    task automatic advance_window(t_in_word w);
        logic [2:0] off;
        int run;
        off = w.seq_num - win_base;
        run = 0;
        if (!w.check_ok) begin
            return;
        end
        if (off >= WINDOW) begin
            note_expected(make_ack({1'b0, w.seq_num}, 1'b0, '0, 1'b1));
            return;
        end
        if (!slot_full[off]) begin
            slot_full[off] = 1'b1;
            slot_word[off] = w.payload_word;
        end
        if (off != 0) begin
            note_expected(make_ack(last_ack, 1'b0, '0, 1'b1));
            return;
        end
        while (run < WINDOW && slot_full[run]) begin
            run++;
        end
        for (int k = 0; k < run; k++) begin
            last_ack = {1'b0, 3'(win_base + k)};
            note_expected(make_ack(last_ack, 1'b1, slot_word[k], k == run - 1));
        end
        for (int k = 0; k < WINDOW; k++) begin
            if (k + run < WINDOW) begin
                slot_full[k] = slot_full[k + run];
                slot_word[k] = slot_word[k + run];
            end else begin
                slot_full[k] = 1'b0;
                slot_word[k] = '0;
            end
        end
        win_base = win_base + 3'(run);
    endtask

    task automatic send_packet(logic [2:0] seq, logic ok, logic [63:0] pay);
        t_in_word w;
        w.seq_num      = seq;
        w.check_ok     = ok;
        w.payload_word = pay;
        while (!calm && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        advance_window(w);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (ack_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [2:0] pick_seq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 3'($urandom_range(0, 7));
        end else if (r < 45) begin
            return win_base;
        end
        return win_base + 3'($urandom_range(1, 4));
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            send_packet(pick_seq(), $urandom_range(0, 99) >= 8, {$urandom, $urandom});
        end
    endtask

    task automatic note_mismatch(string what, t_out_word want, t_out_word got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected ack %0d deliver %0b payload %h last %0b",
                     what, want.ack_num, want.deliver, want.payload_out, want.last_of_run);
            $display("%s: actual ack %0d deliver %0b payload %h last %0b",
                     what, got.ack_num, got.deliver, got.payload_out, got.last_of_run);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ack_queue.size() == 0) begin
                note_mismatch("unexpected word", '0, o_out_word);
            end else begin
                want = ack_queue.pop_front();
                if (o_out_word.ack_num !== want.ack_num || o_out_word.deliver !== want.deliver
                    || o_out_word.payload_out !== want.payload_out
                    || o_out_word.last_of_run !== want.last_of_run) begin
                    note_mismatch("wrong word", want, o_out_word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 22);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("selective_repeat_receiver_unit: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_packet(3'd1, 1'b1, '1);
        send_packet(3'd1, 1'b1, 64'h1111_2222_3333_4444);
        send_packet(3'd0, 1'b0, 64'hdead_beef_0000_0001);
        send_packet(3'd5, 1'b1, '0);
        send_packet(3'd2, 1'b1, 64'h8000_0000_0000_0002);
        send_packet(3'd3, 1'b1, 64'h0123_4567_89ab_cdef);
        send_packet(3'd0, 1'b1, '0);
        send_packet(3'd7, 1'b1, 64'hfedc_ba98_7654_3210);
        send_packet(3'd3, 1'b1, 64'h5555_5555_5555_5555);
        send_packet(3'd4, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
        send_packet(3'd6, 1'b1, 64'h0000_0000_ffff_ffff);
        send_packet(3'd5, 1'b1, 64'hffff_ffff_0000_0000);
        send_packet(3'd0, 1'b0, '1);
        send_packet(3'd7, 1'b0, '1);
        send_packet(3'd0, 1'b1, '1);
        send_packet(3'd7, 1'b1, 64'h0000_0000_0000_0001);
    endtask

    task automatic test_random_traffic();
        send_random(150);
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        send_random(60);
        calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        send_random(40);
    endtask

    task automatic test_sender_pause();
        send_random(20);
        wait_drained();
        send_random(150);
    endtask

    initial begin
        clear_window();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic();
        test_steady_stream();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && ack_queue.size() == 0) begin
            $display("selective_repeat_receiver_unit: match");
        end else begin
            $display("selective_repeat_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule
